>>> design/bisu_pkg.sv
`default_nettype none

package bisu_pkg;

   localparam int NUM_CH      = 4;
   localparam int CHUNK_BYTES = 8;
   localparam int POS_W       = $clog2(CHUNK_BYTES);
   localparam int SAMPLE_W    = 16;
   localparam int OFFSET_W    = 16;
   localparam int FACTOR_W    = 24;
   localparam int VALUE_W     = 40;
   localparam int CLIP_W      = 6;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CLIP_W-1:0]   CLIP_LOW   = 6'd7;
   localparam logic [CLIP_W-1:0]   CLIP_HIGH  = 6'd56;
   localparam logic [SAMPLE_W-1:0] PREV_RESET = 16'h8000;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE = 24'h01_0000;
   localparam logic [POS_W-1:0]    LAST_POS   = POS_W'(CHUNK_BYTES - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OFFSET_CH0 = 4'd0,
      CSR_OFFSET_CH1 = 4'd1,
      CSR_OFFSET_CH2 = 4'd2,
      CSR_OFFSET_CH3 = 4'd3,
      CSR_FACTOR_CH0 = 4'd4,
      CSR_FACTOR_CH1 = 4'd5,
      CSR_FACTOR_CH2 = 4'd6,
      CSR_FACTOR_CH3 = 4'd7
   } csr_index_type;

   typedef logic [SAMPLE_W-1:0]        sample_type;
   typedef logic signed [VALUE_W-1:0]  value_type;
   typedef logic signed [FACTOR_W-1:0] factor_type;

endpackage

`default_nettype wire

>>> design/bisu_lane.sv
`default_nettype none

module bisu_lane
   import bisu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire sample_type          sample,
   input  wire logic [OFFSET_W-1:0] offset,
   input  wire factor_type          factor,
   output value_type                value
);

   sample_type                   prev_ff;
   sample_type                   prev_in;
   value_type                    value_ff;
   value_type                    value_in;
   logic                         clipped;
   logic signed [SAMPLE_W:0]     diff;
   logic signed [SAMPLE_W+FACTOR_W:0] prod;

   // clip mark in the low six bits: fall back to the last good sample
   always_comb begin
      clipped  = (sample[CLIP_W-1:0] == CLIP_LOW) || (sample[CLIP_W-1:0] == CLIP_HIGH);
      prev_in  = clipped ? prev_ff : sample;
      diff     = $signed({1'b0, prev_in}) - $signed({1'b0, offset});
      prod     = diff * factor;
      value_in = prod[VALUE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= PREV_RESET;
      end else if (load) begin
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

`default_nettype wire

>>> design/bit_interleaved_sample_unpacker_core.sv
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_data_byte[7:0]
// rsp     | out       | rsp_valid/rsp_stall  | rsp_value_ch0..3[39:0], signed q.16
// csr     | in        | csr_valid/csr_ready  | csr_index[3:0], csr_wdata[23:0]
//
// one byte is taken every cycle while req_stall is low; the eighth byte of a
// chunk completes it, and the result passes the sample register, then
// clip repair, offset subtract and 17x24 multiply into the output register
// reset (synchronous) clears byte position, valids, offsets, sets factors to 1.0
// and previous samples to 32768
// req_stall rises only while a finished chunk waits and the output is stalled

`default_nettype none

module bit_interleaved_sample_unpacker_core
   import bisu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_data_byte,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output value_type                   rsp_value_ch0,
   output value_type                   rsp_value_ch1,
   output value_type                   rsp_value_ch2,
   output value_type                   rsp_value_ch3,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [OFFSET_W-1:0] offset_ff [NUM_CH];
   factor_type          factor_ff [NUM_CH];

   // byte position within the chunk and gathered bit pairs
   logic [POS_W-1:0]    pos_ff;
   sample_type          partial_ff [NUM_CH];
   sample_type          partial_in [NUM_CH];

   // completed chunk waiting for the lanes
   sample_type          chunk_ff [NUM_CH];
   sample_type          chunk_in [NUM_CH];
   logic                chunk_valid_ff;
   logic                chunk_valid_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   logic                req_accept;
   logic                chunk_done;
   logic                out_free;
   logic                advance;
   value_type           lane_value [NUM_CH];

   assign csr_ready = 1'b1;

   // offsets and factors; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            offset_ff[c] <= '0;
            factor_ff[c] <= FACTOR_ONE;
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET_CH0: offset_ff[0] <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_CH1: offset_ff[1] <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_CH2: offset_ff[2] <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_CH3: offset_ff[3] <= csr_wdata[OFFSET_W-1:0];
            CSR_FACTOR_CH0: factor_ff[0] <= csr_wdata[FACTOR_W-1:0];
            CSR_FACTOR_CH1: factor_ff[1] <= csr_wdata[FACTOR_W-1:0];
            CSR_FACTOR_CH2: factor_ff[2] <= csr_wdata[FACTOR_W-1:0];
            CSR_FACTOR_CH3: factor_ff[3] <= csr_wdata[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake: output register frees when empty or taken this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = chunk_valid_ff && out_free;
   assign req_stall  = chunk_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign chunk_done = req_accept && (pos_ff == LAST_POS);

   // bit placement: byte i carries bit pair 15-2i/14-2i, so slot 7-i = ~pos
   // low nibble gives the upper bit of the pair, high nibble the lower
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         partial_in[c] = partial_ff[c];
         partial_in[c][{~pos_ff, 1'b0} +: 2] = {req_data_byte[3-c], req_data_byte[7-c]};
         // eighth byte fills the last pair directly into the chunk register
         chunk_in[c] = {partial_ff[c][SAMPLE_W-1:2], req_data_byte[3-c], req_data_byte[7-c]};
      end
   end

   assign chunk_valid_in = chunk_done || (chunk_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         chunk_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            pos_ff <= pos_ff + 1'b1;
         end
         chunk_valid_ff <= chunk_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // sample payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         partial_ff <= partial_in;
      end
      if (chunk_done) begin
         chunk_ff <= chunk_in;
      end
   end

   // one lane per channel: clip repair, offset, scale, output register
   for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
      bisu_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .load   (advance),
         .sample (chunk_ff[g]),
         .offset (offset_ff[g]),
         .factor (factor_ff[g]),
         .value  (lane_value[g])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_ch0 = lane_value[0];
   assign rsp_value_ch1 = lane_value[1];
   assign rsp_value_ch2 = lane_value[2];
   assign rsp_value_ch3 = lane_value[3];

endmodule

`default_nettype wire

>>> design/bisu_checker.sv
`default_nettype none

module bisu_checker
   import bisu_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_stall,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire value_type              rsp_value_ch0,
   input wire value_type              rsp_value_ch1,
   input wire value_type              rsp_value_ch2,
   input wire value_type              rsp_value_ch3
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its values
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_value_ch0) && $stable(rsp_value_ch1)
                                 && $stable(rsp_value_ch2) && $stable(rsp_value_ch3))
      else $error("result changed while stalled");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // input backpressure only comes from a blocked output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with output free");

endmodule

bind bit_interleaved_sample_unpacker_core bisu_checker u_bisu_checker (.*);

`default_nettype wire
